// ----- rtl/vmd_pkg.sv -----
// Shared types, constants and sine table builder for the vibrato delay unit.
package vmd_pkg;

  // Field and register widths
  localparam int SAMPLE_W    = 24;
  localparam int CHAN_W      = 1;
  localparam int RATE_W      = 7;
  localparam int DEPTH_W     = 20;
  localparam int FS_W        = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  // Internal formats
  localparam int PHASE_W    = 32;
  localparam int FRAC_W     = 8;
  localparam int SINE_MAG_W = 15;
  localparam int SINE_SH    = 16;
  localparam int SVAL_W     = SINE_SH + 1;

  // Default sizes
  localparam int RING_DEPTH_DEF  = 4096;
  localparam int CHANNELS_DEF    = 2;
  localparam int SINE_DEPTH_DEF  = 1024;

  // Register limits and reset values
  localparam logic [RATE_W-1:0] RATE_MAX = 7'd100;
  localparam logic [FS_W-1:0]   FS_MIN   = 18'd8000;
  localparam logic [FS_W-1:0]   FS_MAX   = 18'd192000;
  localparam logic [FS_W-1:0]   FS_RESET = 18'd48000;

  // Phase step: (RATE_BASE + RATE_SLOPE * rate) * 2^32 / (FS_SCALE * fs)
  localparam int RATE_BASE  = 100;
  localparam int RATE_SLOPE = 99;
  localparam int FS_SCALE   = 1000;
  localparam int DEN_W      = 28;
  localparam logic [PHASE_W-1:0] STEP_RESET =
    PHASE_W'((64'(RATE_BASE) << PHASE_W) / (64'(FS_SCALE) * 64'(FS_RESET)));

  // Offset added to the sine before scaling the depth
  localparam logic [SVAL_W-1:0] SINE_OFFSET = SVAL_W'(1 << SINE_SH);

  // Flip of the sign bit turns a signed sample into an offset-binary one
  localparam logic [SAMPLE_W-1:0] SIGN_BIAS = SAMPLE_W'(1 << (SAMPLE_W - 1));

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RATE  = 2'd0,
    REG_DEPTH = 2'd1,
    REG_FS    = 2'd2
  } vmd_reg_t;

  // Controller to datapath commands, one per state
  typedef struct packed {
    logic load;
    logic mul;
    logic addr_a;
    logic addr_b;
    logic blend;
    logic out_load;
  } vmd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic step_busy;
  } vmd_status_t;

  // Quarter-wave sine entry: odd polynomial in Q30, rounded to Q15, clamped
  function automatic logic [SINE_MAG_W-1:0] quarter_sine_q15(input int unsigned j,
                                                            input int unsigned shift);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned q;
    longint unsigned y;
    z  = 64'(j) << shift;
    z2 = (z * z) >> 30;
    t  = 64'd172272;
    t  = 64'd5026995 - ((z2 * t) >> 30);
    t  = 64'd85569306 - ((z2 * t) >> 30);
    t  = 64'd693598668 - ((z2 * t) >> 30);
    t  = 64'd1686629713 - ((z2 * t) >> 30);
    q  = (z * t) >> 30;
    y  = (q + 64'd16384) >> 15;
    if (y > 64'd32767) y = 64'd32767;
    return y[SINE_MAG_W-1:0];
  endfunction

endpackage

// ----- rtl/vibrato_modulated_delay_unit.sv -----
// A taken input beat steps through the multiply, tap A, tap B, blend and output
// states; output waits for a free result slot. One sample is in flight at a
// time, set by the single ring read port (two taps read in turn) and the
// sequence through the depth multiplier. A rate or sample-rate write holds off
// input while the bit-serial step divider runs. Reset (synchronous, active high)
// empties all rings at once by per-channel fill tracking; no clearing pass.
module vibrato_modulated_delay_unit #(
  parameter int RING_DEPTH       = vmd_pkg::RING_DEPTH_DEF,
  parameter int CHANNELS         = vmd_pkg::CHANNELS_DEF,
  parameter int SINE_TABLE_DEPTH = vmd_pkg::SINE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write_en,
  input  logic [vmd_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [vmd_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [vmd_pkg::CHAN_W-1:0]             chan_index,
  input  logic signed [vmd_pkg::SAMPLE_W-1:0]    sample_in,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [vmd_pkg::SAMPLE_W-1:0]    sample_out
);
  import vmd_pkg::*;

  vmd_cmd_t    cmd;
  vmd_status_t status;
  logic [SAMPLE_W-1:0] out_data;

  vmd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  vmd_datapath #(
    .RING_DEPTH       (RING_DEPTH),
    .CHANNELS         (CHANNELS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .chan_index   (chan_index),
    .sample_in    (sample_in),
    .cmd          (cmd),
    .status       (status),
    .sample_out   (out_data)
  );

  assign sample_out = out_data;

  // One sample in flight: a taken beat closes the input until it is done
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input beat taken while a sample is in flight");

  // No sample starts against a stale phase step
  assert property (@(posedge clk) disable iff (rst)
    status.step_busy |-> item_stall)
    else $error("input open while the phase step is being updated");

  // The output register is loaded only into a free slot
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("result overwritten before it was taken");

  // The datapath sees at most one command per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.addr_a, cmd.addr_b, cmd.blend, cmd.out_load}))
    else $error("overlapping datapath commands");

endmodule

// ----- rtl/vmd_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module vmd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/vmd_step_div.sv -----
// Bit-serial divider that derives the LFO phase step from rate and sample rate.
module vmd_step_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [vmd_pkg::RATE_W-1:0]  rate,
  input  logic [vmd_pkg::FS_W-1:0]    fs,
  output logic [vmd_pkg::PHASE_W-1:0] step,
  output logic                        busy
);
  import vmd_pkg::*;

  localparam int CNT_W = $clog2(PHASE_W + 1);

  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [PHASE_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;

  logic [DEN_W-1:0]   den_calc;
  logic [DEN_W-1:0]   num_calc;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic [DEN_W:0]     rem_sub;
  logic [PHASE_W-1:0] quo_next;

  // Denominator and numerator integer part from the registers
  assign den_calc = DEN_W'(fs) * DEN_W'(FS_SCALE);
  assign num_calc = DEN_W'(RATE_BASE) + DEN_W'(rate) * DEN_W'(RATE_SLOPE);

  // One quotient bit per cycle
  assign rem_sh   = {rem, 1'b0};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_sub  = rem_sh - {1'b0, den};
  assign quo_next = {quo[PHASE_W-2:0], ge};

  // Iterate and hold the finished step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      step <= STEP_RESET;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(PHASE_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        step <= quo_next;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start) begin
      den <= den_calc;
      rem <= num_calc;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= quo_next;
    end
  end

endmodule

// ----- rtl/vmd_datapath.sv -----
// Datapath: configuration registers, LFO, delay arithmetic, ring store and blend.
module vmd_datapath #(
  parameter int RING_DEPTH       = vmd_pkg::RING_DEPTH_DEF,
  parameter int CHANNELS         = vmd_pkg::CHANNELS_DEF,
  parameter int SINE_TABLE_DEPTH = vmd_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [vmd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [vmd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [vmd_pkg::CHAN_W-1:0]          chan_index,
  input  logic [vmd_pkg::SAMPLE_W-1:0]        sample_in,
  input  vmd_pkg::vmd_cmd_t                   cmd,
  output vmd_pkg::vmd_status_t                status,
  output logic [vmd_pkg::SAMPLE_W-1:0]        sample_out
);
  import vmd_pkg::*;

  localparam int ARB       = $clog2(RING_DEPTH);
  localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SB        = $clog2(SINE_TABLE_DEPTH);
  localparam int QB        = SB - 2;
  localparam int QTR       = SINE_TABLE_DEPTH / 4;
  localparam int POS_W     = ARB + FRAC_W;
  localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int PROD_W    = DEPTH_W + SVAL_W;
  localparam int RAW_W     = PROD_W - SINE_SH;
  localparam int DCMP_W    = (RAW_W > POS_W) ? RAW_W : POS_W;
  localparam int BLEND_W   = SAMPLE_W + FRAC_W + 2;
  localparam logic [POS_W-1:0] DLY_MAX = POS_W'((RING_DEPTH - 1) << FRAC_W);
  localparam logic [QB:0]      QTR_V   = (QB + 1)'(QTR);
  localparam logic [BLEND_W-1:0] ROUND_HALF = BLEND_W'(1 << (FRAC_W - 1));

  // Configuration registers
  logic [RATE_W-1:0]  rate;
  logic [DEPTH_W-1:0] depth;
  logic [FS_W-1:0]    fs;
  logic               cfg_changed;
  logic [RATE_W-1:0]  rate_wr;
  logic [FS_W-1:0]    fs_wr;
  logic [RATE_W-1:0]  rate_sat;
  logic [FS_W-1:0]    fs_sat;

  // LFO step unit
  logic [PHASE_W-1:0] step;
  logic               div_busy;

  // Per-channel state
  logic [ARB-1:0]     wp_r     [CHANNELS];
  logic [PHASE_W-1:0] phase_r  [CHANNELS];
  logic               filled_r [CHANNELS];

  // Item registers
  logic [CW-1:0]         ch_q;
  logic                  ok_q;
  logic [SAMPLE_W-1:0]   smp_q;
  logic                  neg_q;
  logic [SINE_MAG_W-1:0] mag_q;
  logic [PROD_W-1:0]     prod_q;
  logic [ARB-1:0]        idx_q;
  logic [FRAC_W-1:0]     frac_q;
  logic                  valid_a_q;
  logic                  valid_b_q;
  logic [SAMPLE_W-1:0]   a_q;
  logic [SAMPLE_W-1:0]   res_q;
  logic [SAMPLE_W-1:0]   out_q;

  // Sine lookup signals
  logic [SINE_MAG_W-1:0] sine_rom [QTR+1];
  logic [CW-1:0]         ch_in;
  logic                  ok_in;
  logic [CW-1:0]         ch_sel;
  logic [PHASE_W-1:0]    phase_sel;
  logic [SB-1:0]         sidx;
  logic [1:0]            quad;
  logic [QB:0]           rom_idx;

  // Delay and address signals
  logic [SVAL_W-1:0]   sval;
  logic [RAW_W-1:0]    dly_raw;
  logic                dly_sat;
  logic [POS_W-1:0]    dly;
  logic [ARB-1:0]      wp_cur;
  logic                filled_cur;
  logic [POS_W-1:0]    pos;
  logic [ARB-1:0]      nxt;
  logic [ARB-1:0]      rd_idx;
  logic [CW+ARB-1:0]   rd_full;
  logic [CW+ARB-1:0]   wr_full;
  logic [SAMPLE_W-1:0] rd_data;
  logic                wr_en;

  // Blend signals
  logic [SAMPLE_W-1:0]        b_val;
  logic [SAMPLE_W-1:0]        ua;
  logic [SAMPLE_W-1:0]        ub;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [BLEND_W-1:0]  blend_prod;
  logic signed [BLEND_W-1:0]  blend_sum;
  logic [SAMPLE_W-1:0]        u_val;

  // Saturate incoming register values
  assign rate_wr  = cfg_data[RATE_W-1:0];
  assign fs_wr    = cfg_data[FS_W-1:0];
  assign rate_sat = (rate_wr > RATE_MAX) ? RATE_MAX : rate_wr;
  assign fs_sat   = (fs_wr < FS_MIN) ? FS_MIN : ((fs_wr > FS_MAX) ? FS_MAX : fs_wr);

  // Take register writes; a rate or sample-rate write restarts the step unit
  always_ff @(posedge clk) begin
    if (rst) begin
      rate        <= '0;
      depth       <= '0;
      fs          <= FS_RESET;
      cfg_changed <= 1'b0;
    end else begin
      cfg_changed <= 1'b0;
      if (cfg_write_en) begin
        case (vmd_reg_t'(cfg_index))
          REG_RATE: begin
            rate        <= rate_sat;
            cfg_changed <= 1'b1;
          end
          REG_DEPTH: depth <= cfg_data[DEPTH_W-1:0];
          REG_FS: begin
            fs          <= fs_sat;
            cfg_changed <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  vmd_step_div u_step_div (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_changed),
    .rate  (rate),
    .fs    (fs),
    .step  (step),
    .busy  (div_busy)
  );

  assign status.step_busy = cfg_changed | div_busy;

  // Quarter-wave sine table, built at elaboration
  for (genvar g = 0; g <= QTR; g++) begin : g_sine
    assign sine_rom[g] = quarter_sine_q15(g, 30 - QB);
  end

  // Select the channel and fold the phase into the quarter table
  assign ch_in     = CW'(chan_index);
  assign ok_in     = int'(chan_index) < CHANNELS;
  assign ch_sel    = ok_in ? ch_in : '0;
  assign phase_sel = phase_r[ch_sel];
  assign sidx      = phase_sel[PHASE_W-1 -: SB];
  assign quad      = sidx[SB-1 -: 2];
  assign rom_idx   = quad[0] ? (QTR_V - {1'b0, sidx[QB-1:0]}) : {1'b0, sidx[QB-1:0]};

  // Scale the depth by one plus half the sine
  assign sval = neg_q ? (SINE_OFFSET - SVAL_W'(mag_q)) : (SINE_OFFSET + SVAL_W'(mag_q));

  // Clamp the delay and form the fractional read position
  assign dly_raw    = prod_q[PROD_W-1:SINE_SH];
  assign dly_sat    = DCMP_W'(dly_raw) > DCMP_W'(DLY_MAX);
  assign dly        = dly_sat ? DLY_MAX : POS_W'(dly_raw);
  assign wp_cur     = wp_r[ch_q];
  assign filled_cur = filled_r[ch_q];
  assign pos        = {wp_cur, FRAC_W'(0)} - dly;
  assign nxt        = idx_q + 1'b1;

  // Ring addresses: first tap, then its neighbor, write at the pointer
  assign rd_idx  = cmd.addr_a ? pos[POS_W-1:FRAC_W] : nxt;
  assign rd_full = {ch_q, rd_idx};
  assign wr_full = {ch_q, wp_cur};
  assign wr_en   = cmd.blend & ok_q;

  vmd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_full[MEM_AW-1:0]),
    .wr_data (smp_q),
    .rd_addr (rd_full[MEM_AW-1:0]),
    .rd_data (rd_data)
  );

  // Linear blend in offset binary: 256*a + f*(b-a), rounded
  assign b_val      = valid_b_q ? rd_data : '0;
  assign ua         = a_q ^ SIGN_BIAS;
  assign ub         = b_val ^ SIGN_BIAS;
  assign diff       = $signed({1'b0, ub}) - $signed({1'b0, ua});
  assign blend_prod = BLEND_W'(diff) * BLEND_W'($signed({1'b0, frac_q}));
  assign blend_sum  = $signed({2'b00, ua, FRAC_W'(0)}) + blend_prod + $signed(ROUND_HALF);
  assign u_val      = blend_sum[SAMPLE_W+FRAC_W-1:FRAC_W];

  // Per-channel pointer, fill flag and phase; advance after the write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]     <= '0;
        phase_r[c]  <= '0;
        filled_r[c] <= 1'b0;
      end
    end else if (cmd.blend && ok_q) begin
      wp_r[ch_q]    <= wp_cur + 1'b1;
      phase_r[ch_q] <= phase_r[ch_q] + step;
      if (wp_cur == '1) filled_r[ch_q] <= 1'b1;
    end
  end

  // Item registers, one group per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_q  <= ch_sel;
      ok_q  <= ok_in;
      smp_q <= sample_in;
      mag_q <= sine_rom[rom_idx];
      neg_q <= quad[1];
    end
    if (cmd.mul) prod_q <= PROD_W'(depth) * PROD_W'(sval);
    if (cmd.addr_a) begin
      idx_q     <= pos[POS_W-1:FRAC_W];
      frac_q    <= pos[FRAC_W-1:0];
      valid_a_q <= filled_cur | (pos[POS_W-1:FRAC_W] < wp_cur);
    end
    if (cmd.addr_b) begin
      a_q       <= valid_a_q ? rd_data : '0;
      valid_b_q <= filled_cur | (nxt < wp_cur);
    end
    if (cmd.blend) res_q <= ok_q ? (u_val ^ SIGN_BIAS) : '0;
    if (cmd.out_load) out_q <= res_q;
  end

  assign sample_out = out_q;

endmodule

// ----- rtl/vmd_ctrl.sv -----
// Controller: sequences one sample through the datapath and owns both handshakes.
module vmd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  vmd_pkg::vmd_status_t status,
  output vmd_pkg::vmd_cmd_t    cmd
);
  import vmd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADDR_A,
    S_ADDR_B,
    S_BLEND,
    S_OUT
  } state_t;

  state_t state;
  logic   slot_free;

  // Take a beat only when idle and the phase step is settled
  assign item_stall = (state != S_IDLE) | status.step_busy;
  assign slot_free  = ~result_valid | ~result_stall;

  // One command per state
  assign cmd.load     = item_valid & ~item_stall;
  assign cmd.mul      = state == S_MUL;
  assign cmd.addr_a   = state == S_ADDR_A;
  assign cmd.addr_b   = state == S_ADDR_B;
  assign cmd.blend    = state == S_BLEND;
  assign cmd.out_load = (state == S_OUT) & slot_free;

  // Advance the sequence and hold the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      case (state)
        S_IDLE:   if (cmd.load) state <= S_MUL;
        S_MUL:    state <= S_ADDR_A;
        S_ADDR_A: state <= S_ADDR_B;
        S_ADDR_B: state <= S_BLEND;
        S_BLEND:  state <= S_OUT;
        S_OUT: begin
          if (cmd.out_load) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for vibrato_modulated_delay_unit: random beats, bit-exact predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vmd_pkg::*;

  localparam int RING_N       = RING_DEPTH_DEF;
  localparam int CHAN_N       = CHANNELS_DEF;
  localparam int SINE_N       = SINE_DEPTH_DEF;
  localparam int LATENCY      = 5;
  localparam int SETTLE       = 2 * LATENCY;
  localparam int RANDOM_BEATS = 650;
  localparam int MAX_REPORTS  = 10;

  // Index past the register list, expected to be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam longint unsigned Q30_UNIT     = 64'd1 << 30;
  localparam longint unsigned MAX_DELAY_Q8 = 64'(RING_N - 1) << FRAC_W;
  localparam longint unsigned SPAN_Q8      = 64'(RING_N) << FRAC_W;
  localparam logic [SAMPLE_W-1:0] PCM_MAX  = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] PCM_MIN  = 24'h800000;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] pcm;
  } voice_beat_t;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0]        cfg_index    = '0;
  logic [CFG_DATA_W-1:0]         cfg_data     = '0;
  logic                          item_valid   = 1'b0;
  logic                          item_stall;
  logic [CHAN_W-1:0]             chan_index   = '0;
  logic signed [SAMPLE_W-1:0]    sample_in    = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]    sample_out;

  vibrato_modulated_delay_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .chan_index   (chan_index),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out)
  );

  // Beats waiting to go out, and delayed samples still owed by the block
  voice_beat_t         beats_to_send [$];
  logic [SAMPLE_W-1:0] due_out [$];

  int unsigned faults     = 0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  bit          idle_on    = 1'b1;

  // Predictor state
  int                  sine_q15 [SINE_N];
  logic [SAMPLE_W-1:0] echo_ring [CHAN_N][RING_N];
  int unsigned         write_slot [CHAN_N];
  logic [PHASE_W-1:0]  lfo_turn [CHAN_N];
  logic [PHASE_W-1:0]  turn_step;
  int unsigned         rate_set;
  int unsigned         depth_set;
  int unsigned         fs_set;

  // Sine table entry: odd terms of sin(pi/2 z) in Horner form, Q30, rounded to Q15
  function automatic int sine_entry(int unsigned k);
    longint unsigned ph, r, z, zz, p, y;
    ph = (64'(k) << 32) / SINE_N;
    r  = ph & (Q30_UNIT - 1);
    z  = ph[30] ? Q30_UNIT - r : r;
    zz = (z * z) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995 - ((zz * p) >> 30);
    p  = 64'd85569306 - ((zz * p) >> 30);
    p  = 64'd693598668 - ((zz * p) >> 30);
    p  = 64'd1686629713 - ((zz * p) >> 30);
    y  = (((z * p) >> 30) + 64'd16384) >> 15;
    if (y > 64'd32767) y = 64'd32767;
    return ph[31] ? -int'(y) : int'(y);
  endfunction

  function automatic void refresh_step();
    turn_step = PHASE_W'(((64'(RATE_BASE) + 64'(RATE_SLOPE) * rate_set) << PHASE_W)
                         / (64'(FS_SCALE) * fs_set));
  endfunction

  // Mirror a register write, with the block's saturation rules
  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_RATE: begin
        rate_set = (data[RATE_W-1:0] > RATE_MAX) ? RATE_MAX : data[RATE_W-1:0];
        refresh_step();
      end
      REG_DEPTH: depth_set = data[DEPTH_W-1:0];
      REG_FS: begin
        fs_set = data[FS_W-1:0];
        if (fs_set < FS_MIN) fs_set = FS_MIN;
        if (fs_set > FS_MAX) fs_set = FS_MAX;
        refresh_step();
      end
      default: ;
    endcase
  endfunction

  // Interpolated read at the modulated delay, then store the new sample and advance
  function automatic logic [SAMPLE_W-1:0] vibrato_tap(int unsigned ch, logic [SAMPLE_W-1:0] pcm);
    int unsigned     wp, idx, nxt;
    int              sv;
    longint unsigned dly, pos, frac, ua, ub, mix;
    wp  = write_slot[ch];
    sv  = sine_q15[int'((64'(lfo_turn[ch]) * SINE_N) >> PHASE_W)];
    dly = (64'(depth_set) * 64'(sv + int'(SINE_OFFSET))) >> SINE_SH;
    if (dly > MAX_DELAY_Q8) dly = MAX_DELAY_Q8;
    pos = ((64'(wp) + RING_N) << FRAC_W) - dly;
    if (pos >= SPAN_Q8) pos -= SPAN_Q8;
    idx  = int'(pos >> FRAC_W);
    frac = pos & 64'hFF;
    nxt  = (idx + 1) % RING_N;
    // offset binary keeps the blend unsigned
    ua  = 64'(echo_ring[ch][idx] ^ SIGN_BIAS);
    ub  = 64'(echo_ring[ch][nxt] ^ SIGN_BIAS);
    mix = ((256 - frac) * ua + frac * ub + 128) >> FRAC_W;
    echo_ring[ch][wp] = pcm;
    write_slot[ch]    = (wp + 1) % RING_N;
    lfo_turn[ch]      = lfo_turn[ch] + turn_step;
    return mix[SAMPLE_W-1:0] ^ SIGN_BIAS;
  endfunction

  function automatic void report_fault(string detail);
    faults++;
    if (faults <= MAX_REPORTS) $display("%0t ns: %s", $realtime, detail);
  endfunction

  function automatic void queue_beat(int unsigned ch, logic [SAMPLE_W-1:0] pcm);
    voice_beat_t b;
    b.chan = CHAN_W'(ch);
    b.pcm  = pcm;
    beats_to_send.push_back(b);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Wait until every beat is taken and every result is back, then let the pipe settle
  task automatic drain();
    while (beats_to_send.size() != 0 || item_valid || due_out.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Input side: present queued beats, predict on acceptance, idle in bursts
  always @(posedge clk) begin : beat_side
    voice_beat_t next_beat;
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall)
        due_out.push_back(vibrato_tap(chan_index, sample_in));
      if (!item_valid || !item_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          next_beat = beats_to_send.pop_front();
          item_valid <= 1'b1;
          chan_index <= next_beat.chan;
          sample_in  <= next_beat.pcm;
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each result beat against the oldest prediction, stall in bursts
  always @(posedge clk) begin : result_side
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_out.size() == 0) begin
          report_fault($sformatf("unexpected sample_out %0d", sample_out));
        end else begin
          want = due_out.pop_front();
          if (sample_out !== want)
            report_fault($sformatf("sample_out expected %0d got %0d", $signed(want), sample_out));
        end
      end
      if (stall_left != 0) stall_left--;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      result_stall <= (stall_left != 0);
    end
  end

  initial begin : stimulus
    int unsigned k, c, batch, random_sent, ch1_share;
    bit          fast;
    logic [CFG_DATA_W-1:0] word;

    // Predictor reset
    for (k = 0; k < SINE_N; k++) sine_q15[k] = sine_entry(k);
    for (c = 0; c < CHAN_N; c++) begin
      for (k = 0; k < RING_N; k++) echo_ring[c][k] = '0;
      write_slot[c] = 0;
      lfo_turn[c]   = '0;
    end
    rate_set  = 0;
    depth_set = 0;
    fs_set    = FS_RESET;
    refresh_step();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: zero depth
    @(negedge clk);
    queue_beat(0, PCM_MAX);
    queue_beat(1, PCM_MIN);
    queue_beat(0, 24'h123456);
    drain();

    // Delay below one sample: the read blends in the slot about to be written
    write_reg(REG_DEPTH, 20'h000C0);
    @(negedge clk);
    queue_beat(0, PCM_MAX);
    queue_beat(0, PCM_MIN);
    queue_beat(1, PCM_MIN);
    queue_beat(1, PCM_MAX);
    queue_beat(0, 24'hFFFFFF);
    queue_beat(1, 24'h000001);
    queue_beat(0, 24'h555555);
    queue_beat(1, 24'hAAAAAA);
    drain();

    // Rate above its limit, sample rate below its floor, delay past the ring
    write_reg(REG_RATE, 20'h0007F);
    write_reg(REG_FS, 20'h00000);
    write_reg(REG_DEPTH, 20'hFFFFF);
    @(negedge clk);
    queue_beat(0, PCM_MIN);
    queue_beat(1, PCM_MAX);
    queue_beat(0, 24'h000000);
    queue_beat(1, 24'hFFFFFF);
    drain();

    // Sample rate above its ceiling, tiny depth, write to an index past the list
    write_reg(REG_RATE, 20'd100);
    write_reg(REG_FS, 20'h3FFFF);
    write_reg(REG_DEPTH, 20'h00030);
    write_reg(REG_SPARE, 20'hFFFFF);
    @(negedge clk);
    queue_beat(1, 24'h7F00FF);
    queue_beat(0, 24'h80FF00);
    queue_beat(1, 24'h0F0F0F);
    queue_beat(0, 24'hF0F0F0);
    drain();

    // Random phases; fast LFO settings dominate so the phase sweeps far
    random_sent = 0;
    while (random_sent < RANDOM_BEATS) begin
      fast = ($urandom_range(0, 4) != 0);
      word = fast ? 20'($urandom_range(90, 127)) : 20'($urandom_range(0, 127));
      if ($urandom_range(0, 3) == 0)
        word[CFG_DATA_W-1:RATE_W] = (CFG_DATA_W - RATE_W)'($urandom());
      write_reg(REG_RATE, word);
      if (fast) word = 20'($urandom_range(0, 12000));
      else if ($urandom_range(0, 3) == 0) word = 20'($urandom());
      else word = 20'($urandom_range(8000, 192000));
      write_reg(REG_FS, word);
      word = ($urandom_range(0, 4) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 40 * 256));
      write_reg(REG_DEPTH, word);
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, 20'($urandom()));

      // lean toward one channel in fast phases so its phase goes past half a turn
      ch1_share = fast ? 15 : 50;
      batch     = $urandom_range(30, 70);
      @(negedge clk);
      idle_on = (random_sent + 120 < RANDOM_BEATS) && ($urandom_range(0, 3) != 0);
      repeat (batch) begin
        if ($urandom_range(0, 9) == 0)
          queue_beat(($urandom_range(0, 99) < ch1_share) ? 1 : 0,
                     $urandom_range(0, 1) ? PCM_MAX : PCM_MIN);
        else
          queue_beat(($urandom_range(0, 99) < ch1_share) ? 1 : 0, SAMPLE_W'($urandom()));
      end
      random_sent += batch;
      drain();
    end

    if (faults == 0) begin
      $display("vibrato_modulated_delay_unit test passed");
    end else begin
      $display("vibrato_modulated_delay_unit test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #600000;
    $display("vibrato_modulated_delay_unit test failed");
    $finish;
  end

endmodule
